// ===== src/tsl_pkg.sv =====
// ============================================================================
// tsl_pkg: shared types and constants of the tournament second-largest core
// Holds the payload structs, the result kind codes and the sizing constants.
// ============================================================================
package tsl_pkg;

    localparam int unsigned MAX_ITEMS = 64;
    localparam int unsigned MAX_DEPTH = 6;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned KIND_W    = 2;

    localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
    localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int unsigned DEP_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_LOSER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOLO   = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    final_item;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [KIND_W-1:0]       kind;
        logic                    overflowed;
        logic                    end_of_run;
    } t_out_item;

endpackage

// ===== src/tsl_ram.sv =====
// ============================================================================
// tsl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module tsl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tournament_second_largest_core.sv =====
// ============================================================================
// tournament_second_largest_core: runner-up search by knockout tournament
// Loads a set of signed values, then walks the champion's path and reports
// every value that lost to the champion, followed by the second largest.
// ============================================================================
//
//  Channel | Handshake                 | Payload     | Moves
//  --------+---------------------------+-------------+---------------------------
//  in      | i_in_valid / o_in_ready   | t_in_item   | one value of the set
//  out     | o_out_valid / i_out_ready | t_out_item  | one loser, the runner-up or a lone value
//
//  Loading takes one request per cycle. After the last value, each level of
//  the champion's path scans its range through the value RAM at one entry
//  per cycle; the registered read and then DECIDE settle its match.
//  Emission then moves the results out as fast as the output side takes them.
//  Reset (synchronous, active low) empties the set; the RAM needs no clear.
//  A stalled output holds the result register; loading of the next set
//  resumes as soon as the last result of a run sits in that register.
//
module tournament_second_largest_core
    import tsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // LOAD collects values; SCAN streams a range out of the RAM; DECIDE
    // plays the match of the two half maxima; EMIT_L and EMIT_B drain the
    // losers and the runner-up; SOLO reports a set of one value.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SOLO,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_L,
        ST_EMIT_B
    } t_state;

    t_state                  r_state;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_ovf;
    logic                    r_run_ovf;
    logic [IDX_W-1:0]        r_lo;
    logic [IDX_W-1:0]        r_hi;
    logic [IDX_W-1:0]        r_addr;
    logic                    r_issue;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic signed [VAL_W-1:0] r_max_l;
    logic signed [VAL_W-1:0] r_max_r;
    logic [CNT_W-1:0]        r_cnt;
    logic [DEP_W-1:0]        r_eidx;
    logic signed [VAL_W-1:0] r_best;
    logic signed [VAL_W-1:0] r_losers [MAX_DEPTH];
    logic                    r_out_vld;
    t_out_item               r_out;

    logic                    w_in_acc;
    logic                    w_store;
    logic [FILL_W-1:0]       w_fill_after;
    logic [FILL_W-1:0]       w_fill_m1;
    logic [IDX_W:0]          w_sum;
    logic [IDX_W-1:0]        w_mid;
    logic                    w_out_free;
    logic                    w_rd_en;
    logic [VAL_W-1:0]        w_rd_raw;
    logic signed [VAL_W-1:0] w_rd_val;
    logic                    w_go_right;
    logic signed [VAL_W-1:0] w_loser;
    logic [IDX_W-1:0]        w_new_lo;
    logic [IDX_W-1:0]        w_new_hi;
    logic                    w_room;
    logic [CNT_W-1:0]        w_cnt_after;
    logic [CNT_W-1:0]        w_cnt_m1;
    logic [CNT_W-1:0]        w_top_idx;
    logic signed [VAL_W-1:0] w_emit_val;

    // Values enter only in LOAD. The RAM is written only there and read only
    // in SCAN, so a read never overlaps a write to the same entry.
    assign o_in_ready   = (r_state == ST_LOAD);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_store      = w_in_acc && (r_fill < FILL_W'(MAX_ITEMS));
    assign w_fill_after = w_store ? (r_fill + FILL_W'(1)) : r_fill;
    assign w_fill_m1    = w_fill_after - FILL_W'(1);

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[IDX_W:1];

    assign w_rd_en  = (r_state == ST_SCAN) && r_issue;
    assign w_rd_val = signed'(w_rd_raw);

    tsl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (r_fill[IDX_W-1:0]),
        .i_wr_data (i_in_item.sample),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_raw)
    );

    // The match of the current range: the left maximum wins ties, so the
    // path turns right only when the right maximum is strictly larger.
    assign w_go_right  = (r_max_l < r_max_r);
    assign w_loser     = w_go_right ? r_max_l : r_max_r;
    assign w_new_lo    = w_go_right ? (w_mid + IDX_W'(1)) : r_lo;
    assign w_new_hi    = w_go_right ? r_hi : w_mid;
    assign w_room      = (r_cnt < CNT_W'(MAX_DEPTH));
    assign w_cnt_after = w_room ? (r_cnt + CNT_W'(1)) : r_cnt;
    assign w_cnt_m1    = w_cnt_after - CNT_W'(1);

    // During emission the deepest stored loser sits at the top index.
    assign w_top_idx  = r_cnt - CNT_W'(1);

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_emit_val = r_losers[r_eidx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        if (i_in_item.final_item) begin
                            r_run_ovf <= r_ovf || !w_store;
                            r_fill    <= '0;
                            r_ovf     <= 1'b0;
                            if (w_fill_after == FILL_W'(1)) begin
                                r_best  <= i_in_item.sample;
                                r_state <= ST_SOLO;
                            end else begin
                                r_lo    <= '0;
                                r_hi    <= w_fill_m1[IDX_W-1:0];
                                r_addr  <= '0;
                                r_issue <= 1'b1;
                                r_cnt   <= '0;
                                r_state <= ST_SCAN;
                            end
                        end else begin
                            r_fill <= w_fill_after;
                            r_ovf  <= r_ovf || !w_store;
                        end
                    end
                end

                ST_SOLO: begin
                    if (w_out_free) begin
                        r_out_vld         <= 1'b1;
                        r_out.result_value <= r_best;
                        r_out.kind        <= KIND_SOLO;
                        r_out.overflowed  <= r_run_ovf;
                        r_out.end_of_run  <= 1'b1;
                        r_state           <= ST_LOAD;
                    end
                end

                ST_SCAN: begin
                    // Issue one read per cycle from lo up to hi.
                    r_rd_vld <= r_issue;
                    r_rd_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == r_hi) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + IDX_W'(1);
                        end
                    end
                    // Fold the returning value into its half's maximum.
                    if (r_rd_vld) begin
                        if (r_rd_idx <= w_mid) begin
                            if ((r_rd_idx == r_lo) || (w_rd_val > r_max_l)) begin
                                r_max_l <= w_rd_val;
                            end
                        end else begin
                            if ((r_rd_idx == w_mid + IDX_W'(1)) ||
                                (w_rd_val > r_max_r)) begin
                                r_max_r <= w_rd_val;
                            end
                        end
                        if (r_rd_idx == r_hi) begin
                            r_rd_vld <= 1'b0;
                            r_state  <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE: begin
                    if (w_room) begin
                        r_losers[r_cnt[DEP_W-1:0]] <= w_loser;
                    end
                    r_cnt <= w_cnt_after;
                    r_lo  <= w_new_lo;
                    r_hi  <= w_new_hi;
                    if (w_new_lo < w_new_hi) begin
                        r_addr  <= w_new_lo;
                        r_issue <= 1'b1;
                        r_state <= ST_SCAN;
                    end else begin
                        r_eidx  <= w_cnt_m1[DEP_W-1:0];
                        r_state <= ST_EMIT_L;
                    end
                end

                ST_EMIT_L: begin
                    // Deepest loser first; the runner-up is their maximum.
                    if (w_out_free) begin
                        r_out_vld          <= 1'b1;
                        r_out.result_value <= w_emit_val;
                        r_out.kind         <= KIND_LOSER;
                        r_out.overflowed   <= r_run_ovf;
                        r_out.end_of_run   <= 1'b0;
                        if ((r_eidx == w_top_idx[DEP_W-1:0]) || (w_emit_val > r_best)) begin
                            r_best <= w_emit_val;
                        end
                        if (r_eidx == '0) begin
                            r_state <= ST_EMIT_B;
                        end else begin
                            r_eidx <= r_eidx - DEP_W'(1);
                        end
                    end
                end

                ST_EMIT_B: begin
                    if (w_out_free) begin
                        r_out_vld          <= 1'b1;
                        r_out.result_value <= r_best;
                        r_out.kind         <= KIND_SECOND;
                        r_out.overflowed   <= r_run_ovf;
                        r_out.end_of_run   <= 1'b1;
                        r_state            <= ST_LOAD;
                    end
                end

                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // A range under scan always holds a real match.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_lo < r_hi))
        else $error("scan range holds fewer than two entries");

    // Reads stay inside the current range.
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> ((r_addr >= r_lo) && (r_addr <= r_hi)))
        else $error("RAM read outside the scan range");

    // The loser buffer never overfills.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DEPTH))
        else $error("loser count beyond buffer depth");

    // Only the closing result of a run carries a non-loser kind.
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.end_of_run == (o_out_item.kind != KIND_LOSER)))
        else $error("end_of_run and kind disagree");

    // A decision either opens a deeper scan or starts emission.
    a_decide_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |=> ((r_state == ST_SCAN) || (r_state == ST_EMIT_L)))
        else $error("unexpected state after a match decision");
`endif

endmodule

// ===== sim/tournament_second_largest_core_tb.sv =====
// ============================================================================
// tournament_second_largest_core_tb: self-checking bench for the runner-up core
// Streams sets of signed values into the core and checks every loser,
// runner-up and lone value against a tournament predictor held in a scoreboard.
// ============================================================================
module tournament_second_largest_core_tb
    import tsl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [VAL_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // The slowest set (64 values) runs the longest tournament, so this margin
    // covers any result still in flight after the last request.
    localparam int unsigned SETTLE_CYCLES = 400;

    // A few hundred requests, each with sender gaps, the longest tournaments
    // and up to seven results under heavy output stalls, stay well below this
    // bound on any correct run.
    localparam int unsigned CYCLE_LIMIT = 400000;

    localparam int unsigned PHASE_REQUESTS = 50;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the value set, plays the tournament
    // when the closing request of a set arrives, and queues the results that
    // the core must produce, in order.
    // ------------------------------------------------------------------------
    class runner_up_scoreboard;

        logic signed [VAL_W-1:0] set_values [MAX_ITEMS];
        int unsigned             set_fill;
        logic                    set_dropped;
        t_out_item               awaited_results [$];
        int unsigned             mismatches;

        function new();
            set_fill    = 0;
            set_dropped = 1'b0;
            mismatches  = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // With ties going to the left entrant, the winner of any range is
        // the leftmost position that holds its largest value.
        function int unsigned range_winner(int unsigned lo, int unsigned hi);
            int unsigned best_idx;
            best_idx = lo;
            for (int unsigned idx = lo + 1; idx <= hi; idx++) begin
                if (set_values[idx] > set_values[best_idx]) begin
                    best_idx = idx;
                end
            end
            return best_idx;
        endfunction

        function void queue_result(logic signed [VAL_W-1:0] value,
                                   logic [KIND_W-1:0] kind, logic last);
            t_out_item res;
            res.result_value = value;
            res.kind         = kind;
            res.overflowed   = set_dropped;
            res.end_of_run   = last;
            awaited_results  = {awaited_results, res};
        endfunction

        function void note_request(t_in_item item);
            logic signed [VAL_W-1:0] path_losers [MAX_DEPTH];
            logic signed [VAL_W-1:0] runner_up;
            int unsigned             lo;
            int unsigned             hi;
            int unsigned             mid;
            int unsigned             left_win;
            int unsigned             right_win;
            int unsigned             depth;

            if (set_fill < MAX_ITEMS) begin
                set_values[set_fill] = item.sample;
                set_fill++;
            end else begin
                set_dropped = 1'b1;
            end
            if (!item.final_item) begin
                return;
            end

            if (set_fill <= 1) begin
                queue_result(set_fill != 0 ? set_values[0] : '0, KIND_SOLO, 1'b1);
            end else begin
                // Follow the champion from the final match downward; each
                // match contributes the entrant it beat, outermost first.
                lo    = 0;
                hi    = set_fill - 1;
                depth = 0;
                while (lo < hi) begin
                    mid       = (lo + hi) / 2;
                    left_win  = range_winner(lo, mid);
                    right_win = range_winner(mid + 1, hi);
                    if (set_values[left_win] < set_values[right_win]) begin
                        if (depth < MAX_DEPTH) begin
                            path_losers[depth] = set_values[left_win];
                            depth++;
                        end
                        lo = mid + 1;
                    end else begin
                        if (depth < MAX_DEPTH) begin
                            path_losers[depth] = set_values[right_win];
                            depth++;
                        end
                        hi = mid;
                    end
                end

                // Deepest loser goes out first; the largest of them is the
                // runner-up and closes the run.
                runner_up = path_losers[depth - 1];
                for (int unsigned pos = depth; pos > 0; pos--) begin
                    queue_result(path_losers[pos - 1], KIND_LOSER, 1'b0);
                    if (path_losers[pos - 1] > runner_up) begin
                        runner_up = path_losers[pos - 1];
                    end
                end
                queue_result(runner_up, KIND_SECOND, 1'b1);
            end

            set_fill    = 0;
            set_dropped = 1'b0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: result_value %0d kind %0d",
                       got.result_value, got.kind);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_value !== want.result_value) begin
                $error("result_value: expected %0d, actual %0d",
                       want.result_value, got.result_value);
                mismatches++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, actual %0b",
                       want.overflowed, got.overflowed);
                mismatches++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $error("end_of_run: expected %0b, actual %0b",
                       want.end_of_run, got.end_of_run);
                mismatches++;
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the core.
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    runner_up_scoreboard     sb;
    logic signed [VAL_W-1:0] set_buf [$];
    int unsigned             send_idle_pct  = 0;
    int unsigned             recv_stall_pct = 0;
    int unsigned             phase_requests;
    int unsigned             cycle_count    = 0;

    always begin
        #6ns i_clk = 1'b1;
        #6ns i_clk = 1'b0;
    end

    tournament_second_largest_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // The output side stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result accepted by the output handshake is checked right away.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    // Watchdog: a hung core ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tournament_second_largest_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------------

    // Presents one request and returns in the time step of its acceptance.
    // Valid is left high there, so the next call either replaces the payload
    // or drops valid in that same step and never drives it twice.
    task automatic send_request(input logic signed [VAL_W-1:0] value,
                                input logic last);
        t_in_item item;
        item.sample     = value;
        item.final_item = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_request(item);
        phase_requests++;
    endtask

    // Sends the values held in set_buf as one set, the last one closing it.
    task automatic send_set_buf();
        for (int idx = 0; idx < set_buf.size(); idx++) begin
            send_request(set_buf[idx], idx == set_buf.size() - 1);
        end
    endtask

    // Holds the input side quiet until the core has delivered every result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Values lean toward small numbers so that ties happen often, with the
    // full range and both extremes mixed in.
    function automatic logic signed [VAL_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return $urandom;
        end else if (pick < 75) begin
            return $signed($urandom_range(8)) - 4;
        end else if (pick < 87) begin
            return $urandom_range(1) ? MOST_POS : MOST_NEG;
        end
        return $urandom_range(300);
    endfunction

    // Mostly short sets; now and then a full store or one that overflows.
    task automatic send_random_set(input int unsigned size);
        set_buf.delete();
        for (int unsigned idx = 0; idx < size; idx++) begin
            set_buf = {set_buf, random_sample()};
        end
        send_set_buf();
    endtask

    function automatic int unsigned random_set_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return $urandom_range(8, 1);
        end else if (pick < 95) begin
            return $urandom_range(40, 9);
        end
        return $urandom_range(68, 64);
    endfunction

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_requests = 0;
        while (phase_requests < PHASE_REQUESTS) begin
            send_random_set(random_set_size());
        end
        // The sender holds off here until the phase has fully drained.
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets: lone values at zero and at both extremes, a tie of
        // two, extremes facing each other in both orders, an all-equal set
        // where the left entrant must keep winning, and a mixed set of eight.
        set_buf = '{32'sd0};
        send_set_buf();
        set_buf = '{MOST_NEG};
        send_set_buf();
        set_buf = '{MOST_POS};
        send_set_buf();
        set_buf = '{32'sd5, 32'sd5};
        send_set_buf();
        set_buf = '{MOST_NEG, MOST_POS};
        send_set_buf();
        set_buf = '{MOST_POS, MOST_NEG};
        send_set_buf();
        set_buf = '{-32'sd1, -32'sd1, -32'sd1};
        send_set_buf();
        set_buf = '{32'sd3, 32'sd1, 32'sd4, 32'sd1, 32'sd5, 32'sd9, 32'sd2, 32'sd6};
        send_set_buf();
        wait_drained();

        // One set one value past capacity: the closing value itself is
        // dropped, yet the tournament still runs over the full store.
        send_random_set(MAX_ITEMS + 1);
        wait_drained();

        // Random sets under each idling pattern.
        run_phase(0, 0);
        run_phase(79, 0);
        run_phase(0, 79);
        run_phase(34, 34);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS tournament_second_largest_core");
        end else begin
            $display("FAIL tournament_second_largest_core");
        end
        $finish;
    end

endmodule

// ===== tournament_second_largest_core.f =====
src/tsl_pkg.sv
src/tsl_ram.sv
src/tournament_second_largest_core.sv
sim/tournament_second_largest_core_tb.sv
